// ===== rtl/core/fdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and series tables for the phasor channel sum block.
package fdd_pkg;

  // Fixed field widths.
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned DmW      = 24;
  localparam int unsigned DelayW   = 24;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned SumW     = 56;

  // The phase product is kept modulo one turn, which is 2^66 at this scale.
  localparam int unsigned PhaseAccW = 66;

  // Depth of the queue between front end and back end.
  localparam int unsigned QueueDepth = 2;

  // 2*pi in Q3.30 and one in Q1.30.
  localparam logic [32:0] TwoPiQ30 = 33'd6746518852;
  localparam logic [30:0] Q30One   = 31'h4000_0000;

  // Series term indexes: sine terms first, then cosine terms.
  localparam int unsigned TermW = 4;
  localparam logic [TermW-1:0] SineFirst = 4'd0;
  localparam logic [TermW-1:0] SineLast  = 4'd3;
  localparam logic [TermW-1:0] CosFirst  = 4'd4;
  localparam logic [TermW-1:0] CosLast   = 4'd8;

  // Divisor of each series term.
  function automatic logic [6:0] term_div(input logic [TermW-1:0] idx);
    logic [6:0] k;
    case (idx)
      4'd0:    k = 7'd72;
      4'd1:    k = 7'd42;
      4'd2:    k = 7'd20;
      4'd3:    k = 7'd6;
      4'd4:    k = 7'd90;
      4'd5:    k = 7'd56;
      4'd6:    k = 7'd30;
      4'd7:    k = 7'd12;
      4'd8:    k = 7'd2;
      default: k = 7'd1;
    endcase
    return k;
  endfunction

  // floor(2^32 / divisor) for each series term.
  function automatic logic [31:0] term_recip(input logic [TermW-1:0] idx);
    logic [31:0] m;
    case (idx)
      4'd0:    m = 32'd59652323;
      4'd1:    m = 32'd102261126;
      4'd2:    m = 32'd214748364;
      4'd3:    m = 32'd715827882;
      4'd4:    m = 32'd47721858;
      4'd5:    m = 32'd76695844;
      4'd6:    m = 32'd143165576;
      4'd7:    m = 32'd357913941;
      4'd8:    m = 32'd2147483648;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/fdd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts channel items and works out the phase with one shared multiplier.
module fdd_front #(
  parameter int unsigned PHASOR_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [fdd_pkg::CfgW-1:0]              sample_time_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fdd_pkg::FreqW-1:0]             spin_freq_i,
  input  logic [fdd_pkg::DmW-1:0]               dm_value_i,
  input  logic [fdd_pkg::DelayW-1:0]            channel_delay_i,
  input  logic signed [fdd_pkg::SampleW-1:0]    sample_re_i,
  input  logic signed [fdd_pkg::SampleW-1:0]    sample_im_i,
  input  logic                                  last_channel_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output logic [PHASOR_BITS-1:0]                push_phase_o,
  output logic signed [fdd_pkg::SampleW-1:0]    push_re_o,
  output logic signed [fdd_pkg::SampleW-1:0]    push_im_o,
  output logic                                  push_last_o
);

  localparam int unsigned AccW = fdd_pkg::PhaseAccW;

  // Step codes of the phase sequence.
  localparam logic [2:0] StMulA  = 3'd0;
  localparam logic [2:0] StMulB  = 3'd1;
  localparam logic [2:0] StLoadB = 3'd2;
  localparam logic [2:0] StPp0   = 3'd3;
  localparam logic [2:0] StPp1   = 3'd4;
  localparam logic [2:0] StPp2   = 3'd5;
  localparam logic [2:0] StPp3   = 3'd6;
  localparam logic [2:0] StPush  = 3'd7;

  logic                              busy_q, busy_d;
  logic [2:0]                        step_q, step_d;
  logic [fdd_pkg::FreqW-1:0]         sf_q;
  logic [fdd_pkg::DmW-1:0]           dm_q;
  logic [fdd_pkg::DelayW-1:0]        dl_q;
  logic signed [fdd_pkg::SampleW-1:0] re_q, im_q;
  logic                              last_q;
  logic [63:0]                       a_q;
  logic [47:0]                       b_q;
  logic [63:0]                       prod_q, prod_d;
  logic [AccW-1:0]                   acc_q, acc_d;
  logic [AccW-1:0]                   acc_final;
  logic [31:0]                       mul_a, mul_b;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      StMulA: begin
        mul_a = sf_q;
        mul_b = sample_time_i;
      end
      StMulB: begin
        mul_a = {8'b0, dm_q};
        mul_b = {8'b0, dl_q};
      end
      StPp0: begin
        mul_a = a_q[31:0];
        mul_b = {8'b0, b_q[23:0]};
      end
      StPp1: begin
        mul_a = a_q[31:0];
        mul_b = {8'b0, b_q[47:24]};
      end
      StPp2: begin
        mul_a = a_q[63:32];
        mul_b = {8'b0, b_q[23:0]};
      end
      StPp3: begin
        mul_a = a_q[63:32];
        mul_b = {8'b0, b_q[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = {32'b0, mul_a} * {32'b0, mul_b};

  // Partial products land in the modulo-one accumulator at their weights.
  assign acc_final = acc_q + ({2'b0, prod_q} << 56);

  always_comb begin
    acc_d = acc_q;
    case (step_q)
      StPp1:   acc_d = {2'b0, prod_q};
      StPp2:   acc_d = acc_q + ({2'b0, prod_q} << 24);
      StPp3:   acc_d = acc_q + ({2'b0, prod_q} << 32);
      default: acc_d = acc_q;
    endcase
  end

  // Sequencer control.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        step_d = StMulA;
      end
    end else if (step_q == StPush) begin
      if (push_ready_i) begin
        busy_d = 1'b0;
      end
    end else begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StMulA;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Item payload and arithmetic registers; the last partial product holds while
  // the push waits.
  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      sf_q   <= spin_freq_i;
      dm_q   <= dm_value_i;
      dl_q   <= channel_delay_i;
      re_q   <= sample_re_i;
      im_q   <= sample_im_i;
      last_q <= last_channel_i;
    end
    if (step_q == StMulB) begin
      a_q <= prod_q;
    end
    if (step_q == StLoadB) begin
      b_q <= prod_q[47:0];
    end
    if (step_q != StPush) begin
      prod_q <= prod_d;
    end
    acc_q  <= acc_d;
  end

  assign in_ready_o   = !busy_q;
  assign push_valid_o = busy_q && (step_q == StPush);
  assign push_phase_o = acc_final[AccW-1 -: PHASOR_BITS];
  assign push_re_o    = re_q;
  assign push_im_o    = im_q;
  assign push_last_o  = last_q;

endmodule

// ===== rtl/core/fdd_queue.sv =====
`timescale 1ns / 1ps
// Short register queue that decouples the front end from the back end.
module fdd_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/core/fdd_back.sv =====
`timescale 1ns / 1ps
// Back end: phasor series, complex product and saturating accumulation.
module fdd_back #(
  parameter int unsigned PHASOR_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  logic [PHASOR_BITS-1:0]              pop_phase_i,
  input  logic signed [fdd_pkg::SampleW-1:0]  pop_re_i,
  input  logic signed [fdd_pkg::SampleW-1:0]  pop_im_i,
  input  logic                                pop_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fdd_pkg::SumW-1:0]     sum_re_o,
  output logic signed [fdd_pkg::SumW-1:0]     sum_im_o
);

  localparam int unsigned SumW = fdd_pkg::SumW;
  localparam int unsigned PB   = PHASOR_BITS;

  // Sequencer states.
  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] STheta  = 4'd1;
  localparam logic [3:0] SSqr    = 4'd2;
  localparam logic [3:0] STLoad  = 4'd3;
  localparam logic [3:0] SItMul  = 4'd4;
  localparam logic [3:0] SItDiv  = 4'd5;
  localparam logic [3:0] SItFix  = 4'd6;
  localparam logic [3:0] SSinMul = 4'd7;
  localparam logic [3:0] SSinGet = 4'd8;
  localparam logic [3:0] SPhasor = 4'd9;
  localparam logic [3:0] SCm0    = 4'd10;
  localparam logic [3:0] SCm1    = 4'd11;
  localparam logic [3:0] SCm2    = 4'd12;
  localparam logic [3:0] SCm3    = 4'd13;
  localparam logic [3:0] SCm4    = 4'd14;
  localparam logic [3:0] SAcc    = 4'd15;

  // Quadrant codes.
  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;

  localparam logic signed [SumW:0] SatMax = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SatMin = {2'b11, {(SumW-1){1'b0}}};

  logic [3:0]                          state_q, state_d;
  logic [PB-1:0]                       phase_q;
  logic signed [fdd_pkg::SampleW-1:0]  sr_q, si_q;
  logic                                last_q;
  logic [64:0]                         prod_q, prod_d;
  logic [32:0]                         mul_a;
  logic [31:0]                         mul_b;
  logic [30:0]                         theta_q;
  logic [31:0]                         t_q;
  logic [30:0]                         u_q;
  logic [31:0]                         x_q;
  logic [30:0]                         sv_q;
  logic [fdd_pkg::TermW-1:0]           iter_q;
  logic signed [15:0]                  cs_q, sn_q, cs_d, sn_d;
  logic signed [23:0]                  cm_a;
  logic signed [15:0]                  cm_b;
  logic signed [39:0]                  cp_q, cp_d;
  logic signed [40:0]                  pr_q, pi_q;
  logic signed [SumW-1:0]              acc_re_q, acc_im_q;
  logic signed [SumW-1:0]              sat_re, sat_im;
  logic                                out_valid_q;
  logic signed [SumW-1:0]              sum_re_q, sum_im_q;
  logic [31:0]                         quo;
  logic [38:0]                         quo_k;
  logic [31:0]                         rem;
  logic [31:0]                         quo_fix;
  logic [30:0]                         u_new;
  logic [6:0]                          div_k;
  logic [14:0]                         s15, c15;
  logic                                out_free;

  // Rounds a Q1.30 value to Q0.15 with an upper cap.
  function automatic logic [14:0] to_q15(input logic [30:0] v);
    logic [31:0] s;
    s = {1'b0, v} + 32'h0000_4000;
    return (s[31:15] > 17'd32767) ? 15'h7fff : s[29:15];
  endfunction

  // Adds with saturation to the accumulator range.
  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [40:0] b);
    logic signed [SumW:0] s;
    s = (SumW+1)'(a) + (SumW+1)'(b);
    if (s > SatMax) begin
      return SatMax[SumW-1:0];
    end else if (s < SatMin) begin
      return SatMin[SumW-1:0];
    end
    return s[SumW-1:0];
  endfunction

  // Operand selection for the shared unsigned multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      STheta: begin
        mul_a = fdd_pkg::TwoPiQ30;
        mul_b = {{(34-PB){1'b0}}, phase_q[PB-3:0]};
      end
      SSqr: begin
        mul_a = {2'b0, prod_q[PB+30:PB]};
        mul_b = {1'b0, prod_q[PB+30:PB]};
      end
      SItMul: begin
        mul_a = {1'b0, t_q};
        mul_b = {1'b0, u_q};
      end
      SItDiv: begin
        mul_a = {1'b0, prod_q[61:30]};
        mul_b = fdd_pkg::term_recip(iter_q);
      end
      SSinMul: begin
        mul_a = {2'b0, theta_q};
        mul_b = {1'b0, u_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 65'(mul_a) * 65'(mul_b);

  // Quotient from the reciprocal product, corrected by one where the remainder allows.
  assign div_k   = fdd_pkg::term_div(iter_q);
  assign quo     = prod_q[63:32];
  assign quo_k   = 39'(quo) * 39'(div_k);
  assign rem     = x_q - quo_k[31:0];
  assign quo_fix = quo + 32'(rem >= 32'(div_k));
  assign u_new   = (quo_fix >= 32'(fdd_pkg::Q30One)) ? '0
                 : 31'(32'(fdd_pkg::Q30One) - quo_fix);

  // Phasor from the series results and the quadrant.
  assign s15 = to_q15(sv_q);
  assign c15 = to_q15(u_q);

  always_comb begin
    case (phase_q[PB-1:PB-2])
      Quad0: begin
        cs_d = $signed({1'b0, c15});
        sn_d = $signed({1'b0, s15});
      end
      Quad1: begin
        cs_d = -$signed({1'b0, s15});
        sn_d = $signed({1'b0, c15});
      end
      Quad2: begin
        cs_d = -$signed({1'b0, c15});
        sn_d = -$signed({1'b0, s15});
      end
      default: begin
        cs_d = $signed({1'b0, s15});
        sn_d = -$signed({1'b0, c15});
      end
    endcase
  end

  // Operand selection for the signed complex product.
  always_comb begin
    cm_a = sr_q;
    cm_b = cs_q;
    case (state_q)
      SCm1: begin
        cm_a = si_q;
        cm_b = sn_q;
      end
      SCm2: begin
        cm_a = sr_q;
        cm_b = sn_q;
      end
      SCm3: begin
        cm_a = si_q;
        cm_b = cs_q;
      end
      default: begin
        cm_a = sr_q;
        cm_b = cs_q;
      end
    endcase
  end

  assign cp_d = 40'(cm_a) * 40'(cm_b);

  assign sat_re   = sat_add(acc_re_q, pr_q);
  assign sat_im   = sat_add(acc_im_q, pi_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   state_d = pop_valid_i ? STheta : SIdle;
      STheta:  state_d = SSqr;
      SSqr:    state_d = STLoad;
      STLoad:  state_d = SItMul;
      SItMul:  state_d = SItDiv;
      SItDiv:  state_d = SItFix;
      SItFix: begin
        if (iter_q == fdd_pkg::SineLast) begin
          state_d = SSinMul;
        end else if (iter_q == fdd_pkg::CosLast) begin
          state_d = SPhasor;
        end else begin
          state_d = SItMul;
        end
      end
      SSinMul: state_d = SSinGet;
      SSinGet: state_d = SItMul;
      SPhasor: state_d = SCm0;
      SCm0:    state_d = SCm1;
      SCm1:    state_d = SCm2;
      SCm2:    state_d = SCm3;
      SCm3:    state_d = SCm4;
      SCm4:    state_d = SAcc;
      SAcc:    state_d = (!last_q || out_free) ? SIdle : SAcc;
      default: state_d = SIdle;
    endcase
  end

  // Control state, accumulators and the output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
      iter_q      <= fdd_pkg::SineFirst;
    end else begin
      state_q <= state_d;
      // A new sum takes priority over clearing the transferred one.
      if (state_q == SAcc && last_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        STLoad:  iter_q <= fdd_pkg::SineFirst;
        SSinGet: iter_q <= fdd_pkg::CosFirst;
        SItFix: begin
          if (iter_q != fdd_pkg::SineLast && iter_q != fdd_pkg::CosLast) begin
            iter_q <= iter_q + fdd_pkg::TermW'(1);
          end
        end
        SAcc: begin
          if (!last_q) begin
            acc_re_q <= sat_re;
            acc_im_q <= sat_im;
          end else if (out_free) begin
            acc_re_q <= '0;
            acc_im_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    cp_q   <= cp_d;
    case (state_q)
      SIdle: begin
        if (pop_valid_i) begin
          phase_q <= pop_phase_i;
          sr_q    <= pop_re_i;
          si_q    <= pop_im_i;
          last_q  <= pop_last_i;
        end
      end
      SSqr:    theta_q <= prod_q[PB+30:PB];
      STLoad: begin
        t_q <= prod_q[61:30];
        u_q <= fdd_pkg::Q30One;
      end
      SItDiv:  x_q <= prod_q[61:30];
      SItFix:  u_q <= u_new;
      SSinGet: begin
        sv_q <= prod_q[60:30];
        u_q  <= fdd_pkg::Q30One;
      end
      SPhasor: begin
        cs_q <= cs_d;
        sn_q <= sn_d;
      end
      SCm1:    pr_q <= 41'(cp_q);
      SCm2:    pr_q <= pr_q - 41'(cp_q);
      SCm3:    pi_q <= 41'(cp_q);
      SCm4:    pi_q <= pi_q + 41'(cp_q);
      SAcc: begin
        if (last_q && out_free) begin
          sum_re_q <= sat_re;
          sum_im_q <= sat_im;
        end
      end
      default: begin
      end
    endcase
  end

  assign pop_ready_o = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign sum_re_o    = sum_re_q;
  assign sum_im_o    = sum_im_q;

endmodule

// ===== rtl/core/fdd_phasor_channel_sum.sv =====
`timescale 1ns / 1ps
// Top level: channel phasor sum with APB configuration, front end, queue and back end.
// The back end's shared multiplier runs the 9-term phasor series for each item.
// Each half takes a new item only when it is done with the last; the queue sits between them.
// Reset: sample_time returns to 274878, the running sum clears, no result pending.
module fdd_phasor_channel_sum #(
  parameter int unsigned PHASOR_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [fdd_pkg::CfgAddrW-1:0]            paddr,
  input  logic [fdd_pkg::CfgW-1:0]                pwdata,
  output logic [fdd_pkg::CfgW-1:0]                prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [fdd_pkg::FreqW-1:0]               spin_freq_i,
  input  logic [fdd_pkg::DmW-1:0]                 dm_value_i,
  input  logic [fdd_pkg::DelayW-1:0]              channel_delay_i,
  input  logic signed [fdd_pkg::SampleW-1:0]      sample_re_i,
  input  logic signed [fdd_pkg::SampleW-1:0]      sample_im_i,
  input  logic                                    last_channel_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [fdd_pkg::SumW-1:0]         sum_re_o,
  output logic signed [fdd_pkg::SumW-1:0]         sum_im_o
);

  localparam int unsigned SampleW = fdd_pkg::SampleW;
  localparam int unsigned QWidth  = PHASOR_BITS + 2 * SampleW + 1;
  localparam int unsigned IdxW    = fdd_pkg::CfgAddrW - 2;
  localparam logic [IdxW-1:0] RegSampleTime = '0;
  localparam logic [fdd_pkg::CfgW-1:0] SampleTimeReset = 32'd274878;

  logic [fdd_pkg::CfgW-1:0]    sample_time_q;
  logic                        cfg_wr;
  logic [IdxW-1:0]             cfg_idx;
  logic                        push_valid, push_ready, push_last;
  logic [PHASOR_BITS-1:0]      push_phase, pop_phase;
  logic signed [SampleW-1:0]   push_re, push_im, pop_re, pop_im;
  logic                        pop_valid, pop_ready, pop_last;
  logic [QWidth-1:0]           q_wr_data, q_rd_data;

  // Configuration register file.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[fdd_pkg::CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == RegSampleTime) ? sample_time_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_time_q <= SampleTimeReset;
    end else if (cfg_wr && cfg_idx == RegSampleTime) begin
      sample_time_q <= pwdata;
    end
  end

  // Phase computation.
  fdd_front #(
    .PHASOR_BITS(PHASOR_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_time_i   (sample_time_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .spin_freq_i     (spin_freq_i),
    .dm_value_i      (dm_value_i),
    .channel_delay_i (channel_delay_i),
    .sample_re_i     (sample_re_i),
    .sample_im_i     (sample_im_i),
    .last_channel_i  (last_channel_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_phase_o    (push_phase),
    .push_re_o       (push_re),
    .push_im_o       (push_im),
    .push_last_o     (push_last)
  );

  // Queue between the two halves.
  assign q_wr_data = {push_last, push_re, push_im, push_phase};
  assign pop_phase = q_rd_data[PHASOR_BITS-1:0];
  assign pop_im    = q_rd_data[PHASOR_BITS +: SampleW];
  assign pop_re    = q_rd_data[PHASOR_BITS + SampleW +: SampleW];
  assign pop_last  = q_rd_data[QWidth-1];

  fdd_queue #(
    .Width(QWidth),
    .Depth(fdd_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (q_wr_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (q_rd_data)
  );

  // Phasor, product and accumulation.
  fdd_back #(
    .PHASOR_BITS(PHASOR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_phase_i (pop_phase),
    .pop_re_i    (pop_re),
    .pop_im_i    (pop_im),
    .pop_last_i  (pop_last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sum_re_o    (sum_re_o),
    .sum_im_o    (sum_im_o)
  );

endmodule
